[hdl/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg: shared constants for the prime factor count range sum block
// Field widths and the default table size used by the top, builder and query modules.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int VALUE_W       = 16;      // width of a range bound
   localparam int TOTAL_W       = 18;      // width of a factor total
   localparam int MAX_VALUE_DEF = 65536;   // table covers 0 .. MAX_VALUE-1

endpackage

[hdl/prime_factor_count_range_sum_top.sv]
// ----------------------------------------------------------------------------
// prime_factor_count_range_sum_top: range sum of prime factor counts
// Answers "how many prime factors, with multiplicity, lie in low..high".
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one range low..high per request. Result channel
//   (rsp_*): one total per request, in request order, with an error flag in
//   rsp_tuser when low is zero, low exceeds high or high is past the table.
//   After reset the block builds its table and holds req_tready low until
//   the build ends. The build clears the table, scans every candidate
//   prime, marks every multiple of every prime power and forms prefix
//   totals.
//   Queries then run one per cycle through three register stages: bound
//   capture, two table reads on separate ports, subtract. When the receiver
//   stalls, the result holds in the output stage and the earlier stages keep
//   filling; req_tready drops only once all three are full. Reset drops all
//   queued work and restarts the build.
// ----------------------------------------------------------------------------
module prime_factor_count_range_sum_top #(
   parameter int MAX_VALUE = pfc_pkg::MAX_VALUE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] range_low, [31:16] range_high
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [17:0] factor_total, [23:18] zero
   output logic [0:0]  rsp_tuser    // [0] range_error
);

   import pfc_pkg::*;

   localparam int AW = $clog2(MAX_VALUE);

   // builder side of the table
   logic               build_done;
   logic               b_wr_en;
   logic [AW-1:0]      b_wr_addr;
   logic [TOTAL_W-1:0] b_wr_data;
   logic               b_rd_en;
   logic [AW-1:0]      b_rd_addr;

   // query side of the table
   logic               q_rd_en;
   logic [AW-1:0]      q_hi_addr;
   logic [AW-1:0]      q_lo_addr;

   // shared table ports
   logic               rd_a_en;
   logic [AW-1:0]      rd_a_addr;
   logic [TOTAL_W-1:0] rd_a_data;
   logic [TOTAL_W-1:0] rd_b_data;

   logic [TOTAL_W-1:0] total;
   logic               error;

   // port A belongs to the builder until the build ends, then to queries
   assign rd_a_en   = build_done ? q_rd_en   : b_rd_en;
   assign rd_a_addr = build_done ? q_hi_addr : b_rd_addr;

   pfc_table #(
      .DEPTH (MAX_VALUE),
      .AW    (AW),
      .DW    (TOTAL_W)
   ) u_table (
      .clock     (clock),
      .wr_en     (b_wr_en),
      .wr_addr   (b_wr_addr),
      .wr_data   (b_wr_data),
      .rd_a_en   (rd_a_en),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_en   (q_rd_en),
      .rd_b_addr (q_lo_addr),
      .rd_b_data (rd_b_data)
   );

   pfc_build #(
      .MAX_VALUE (MAX_VALUE),
      .AW        (AW)
   ) u_build (
      .clock      (clock),
      .reset      (reset),
      .build_done (build_done),
      .wr_en      (b_wr_en),
      .wr_addr    (b_wr_addr),
      .wr_data    (b_wr_data),
      .rd_en      (b_rd_en),
      .rd_addr    (b_rd_addr),
      .rd_data    (rd_a_data)
   );

   pfc_query #(
      .MAX_VALUE (MAX_VALUE),
      .AW        (AW)
   ) u_query (
      .clock      (clock),
      .reset      (reset),
      .build_done (build_done),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_low     (req_tdata[15:0]),
      .in_high    (req_tdata[31:16]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_total  (total),
      .out_error  (error),
      .rd_en      (q_rd_en),
      .rd_hi_addr (q_hi_addr),
      .rd_lo_addr (q_lo_addr),
      .rd_hi_data (rd_a_data),
      .rd_lo_data (rd_b_data)
   );

   assign rsp_tdata = {6'd0, total};
   assign rsp_tuser = error;

endmodule

[hdl/pfc_table.sv]
// ----------------------------------------------------------------------------
// pfc_table: one-write, two-read table memory
// Holds factor counts during the build and prefix totals afterwards.
// ----------------------------------------------------------------------------
module pfc_table #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16,
   parameter int DW    = 18
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_a_en,
   input  logic [AW-1:0] rd_a_addr,
   output logic [DW-1:0] rd_a_data,
   input  logic          rd_b_en,
   input  logic [AW-1:0] rd_b_addr,
   output logic [DW-1:0] rd_b_data
);

   logic [DW-1:0] entry_ff [DEPTH];
   logic [DW-1:0] rd_a_ff;
   logic [DW-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_a_en) begin
         rd_a_ff <= entry_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= entry_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

[hdl/pfc_build.sv]
// ----------------------------------------------------------------------------
// pfc_build: table builder sequencer
// Clears the table, sieves prime powers into per-value factor counts, then
// turns the counts into running prefix totals in place.
// ----------------------------------------------------------------------------
module pfc_build #(
   parameter int MAX_VALUE = 65536,
   parameter int AW        = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   output logic                         build_done,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic [pfc_pkg::TOTAL_W-1:0]  wr_data,
   output logic                         rd_en,
   output logic [AW-1:0]                rd_addr,
   input  logic [pfc_pkg::TOTAL_W-1:0]  rd_data
);

   import pfc_pkg::*;

   localparam int AW1 = AW + 1;
   localparam int PW  = 2 * AW1;
   localparam logic [AW1-1:0] LAST = AW1'(MAX_VALUE - 1);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_SCAN_RD  = 3'd1;
   localparam logic [2:0] ST_SCAN_CHK = 3'd2;
   localparam logic [2:0] ST_MARK_RD  = 3'd3;
   localparam logic [2:0] ST_MARK_WR  = 3'd4;
   localparam logic [2:0] ST_SUM_RD   = 3'd5;
   localparam logic [2:0] ST_SUM_WR   = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [AW1-1:0]     cnt_ff, cnt_in;
   logic [AW1-1:0]     p_ff, p_in;
   logic [AW1-1:0]     q_ff, q_in;
   logic [PW-1:0]      prod_ff;
   logic [TOTAL_W-1:0] acc_ff, acc_in;
   logic [AW1-1:0]     step;
   logic [TOTAL_W-1:0] sum;

   assign step = cnt_ff + q_ff;
   assign sum  = acc_ff + rd_data;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      acc_in   = acc_ff;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff[AW-1:0];
      wr_data  = '0;
      rd_en    = 1'b0;
      rd_addr  = cnt_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (cnt_ff == LAST) begin
               p_in     = AW1'(2);
               state_in = ST_SCAN_RD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCAN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = p_ff[AW-1:0];
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            // no smaller prime touched p: p is prime
            if (rd_data == '0) begin
               q_in     = p_ff;
               cnt_in   = p_ff;
               state_in = ST_MARK_RD;
            end else if (p_ff == LAST) begin
               cnt_in   = AW1'(1);
               acc_in   = '0;
               state_in = ST_SUM_RD;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_MARK_RD: begin
            rd_en    = 1'b1;
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data + 1'b1;
            if (step <= LAST) begin
               cnt_in   = step;
               state_in = ST_MARK_RD;
            end else if (prod_ff <= PW'(LAST)) begin
               // advance to the next power of the prime
               q_in     = AW1'(prod_ff);
               cnt_in   = AW1'(prod_ff);
               state_in = ST_MARK_RD;
            end else if (p_ff == LAST) begin
               cnt_in   = AW1'(1);
               acc_in   = '0;
               state_in = ST_SUM_RD;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SUM_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SUM_WR;
         end
         ST_SUM_WR: begin
            wr_en   = 1'b1;
            wr_data = sum;
            acc_in  = sum;
            if (cnt_ff == LAST) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_SUM_RD;
            end
         end
         ST_DONE: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      q_ff    <= q_in;
      acc_ff  <= acc_in;
      prod_ff <= PW'(q_ff) * PW'(p_ff);
   end

   assign build_done = (state_ff == ST_DONE);

endmodule

[hdl/pfc_query.sv]
// ----------------------------------------------------------------------------
// pfc_query: three-stage range query pipeline
// Capture the bounds, read two prefix entries, subtract and hold the result.
// ----------------------------------------------------------------------------
module pfc_query #(
   parameter int MAX_VALUE = 65536,
   parameter int AW        = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         build_done,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [pfc_pkg::VALUE_W-1:0]  in_low,
   input  logic [pfc_pkg::VALUE_W-1:0]  in_high,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [pfc_pkg::TOTAL_W-1:0]  out_total,
   output logic                         out_error,
   output logic                         rd_en,
   output logic [AW-1:0]                rd_hi_addr,
   output logic [AW-1:0]                rd_lo_addr,
   input  logic [pfc_pkg::TOTAL_W-1:0]  rd_hi_data,
   input  logic [pfc_pkg::TOTAL_W-1:0]  rd_lo_data
);

   import pfc_pkg::*;

   localparam int AW1 = AW + 1;
   localparam int CW  = (AW1 > VALUE_W) ? AW1 : VALUE_W;

   logic               s1_v_ff, s2_v_ff, s3_v_ff;
   logic               s1_v_in, s2_v_in, s3_v_in;
   logic [VALUE_W-1:0] s1_lo_ff, s1_hi_ff;
   logic               s2_err_ff;
   logic [TOTAL_W-1:0] s3_total_ff;
   logic               s3_err_ff;
   logic               rdy1, rdy2, rdy3;
   logic               take, load2, load3;
   logic               err;

   assign rdy3  = !s3_v_ff || out_ready;
   assign load3 = s2_v_ff && rdy3;
   assign rdy2  = !s2_v_ff || rdy3;
   assign load2 = s1_v_ff && rdy2;
   assign rdy1  = !s1_v_ff || rdy2;

   assign in_ready = build_done && rdy1;
   assign take     = in_valid && in_ready;

   assign err = (s1_lo_ff == '0) || (s1_lo_ff > s1_hi_ff)
             || (CW'(s1_hi_ff) >= CW'(MAX_VALUE));

   assign rd_en      = load2;
   assign rd_hi_addr = AW'(s1_hi_ff);
   assign rd_lo_addr = AW'(s1_lo_ff - 1'b1);

   assign s1_v_in = take  || (s1_v_ff && !load2);
   assign s2_v_in = load2 || (s2_v_ff && !load3);
   assign s3_v_in = load3 || (s3_v_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_lo_ff <= in_low;
         s1_hi_ff <= in_high;
      end
      if (load2) begin
         s2_err_ff <= err;
      end
      if (load3) begin
         s3_err_ff   <= s2_err_ff;
         s3_total_ff <= s2_err_ff ? '0 : TOTAL_W'(rd_hi_data - rd_lo_data);
      end
   end

   assign out_valid = s3_v_ff;
   assign out_total = s3_total_ff;
   assign out_error = s3_err_ff;

endmodule
